[hw/rtl/itda_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itda_pkg
// Shared types and constants of the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

   localparam int VALUE_W       = 64;
   localparam int CHAR_W        = 8;
   localparam int MODE_W        = 2;
   localparam int BITS_PER_STEP = 8;
   localparam int STEP_W        = 4;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [MODE_W-1:0] MODE_RAW = 2'd0;
   localparam logic [MODE_W-1:0] MODE_16  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_32  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_64  = 2'd3;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

   // magnitude is left-aligned so its most significant bit sits at the top
   typedef struct packed {
      logic [VALUE_W-1:0] mag;
      logic               neg;
      logic [MODE_W-1:0]  mode;
   } task_type;

   typedef struct packed {
      logic can_push;
      logic can_pop;
   } queue_stat_type;

endpackage
`default_nettype wire

[hw/rtl/itda_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itda_front
// Request intake: masks the value to its width, detects the sign, takes the
// unsigned magnitude and left-aligns it for the back end.
// ----------------------------------------------------------------------------
module itda_front import itda_pkg::*; (
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic [MODE_W-1:0]  req_mode,
   input  wire logic               req_is_signed,
   input  wire queue_stat_type     q_stat,
   output logic                    push,
   output task_type                push_task
);

   logic [VALUE_W-1:0] mask;
   logic [VALUE_W-1:0] masked;
   logic [VALUE_W-1:0] mag;
   logic               sign_bit;
   logic [5:0]         align;

   always_comb begin
      unique case (req_mode)
         MODE_RAW: begin
            mask     = 64'h0000_0000_0000_00FF;
            align    = 6'd56;
         end
         MODE_16: begin
            mask     = 64'h0000_0000_0000_FFFF;
            align    = 6'd48;
         end
         MODE_32: begin
            mask     = 64'h0000_0000_FFFF_FFFF;
            align    = 6'd32;
         end
         default: begin
            mask     = 64'hFFFF_FFFF_FFFF_FFFF;
            align    = 6'd0;
         end
      endcase
      masked = req_value & mask;
      unique case (req_mode)
         MODE_RAW: sign_bit = masked[7];
         MODE_16:  sign_bit = masked[15];
         MODE_32:  sign_bit = masked[31];
         default:  sign_bit = masked[63];
      endcase
      push_task.neg  = req_is_signed & sign_bit;
      mag            = push_task.neg ? ((~masked + 64'd1) & mask) : masked;
      push_task.mag  = mag << align;
      push_task.mode = req_mode;
   end

   assign req_ready = q_stat.can_push;
   assign push      = req_valid & q_stat.can_push;

endmodule
`default_nettype wire

[hw/rtl/itda_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itda_queue
// Two-entry queue of classified requests between front and back end.
// ----------------------------------------------------------------------------
module itda_queue import itda_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire task_type push_task,
   input  wire logic     pop,
   output task_type      pop_task,
   output queue_stat_type q_stat
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   task_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_stat.can_push = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign q_stat.can_pop  = (count_ff != '0);
   assign pop_task        = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_task;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/itda_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// itda_back
// Conversion and emission: shift-add-3 binary to BCD, eight bits a cycle,
// then a leading-zero count and one character per cycle, while the output
// is not stalled, into the output register; raw bytes skip conversion and count.
// ----------------------------------------------------------------------------
module itda_back import itda_pkg::*; #(
   parameter int MAX_DIGITS = 20
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_stat_type q_stat,
   input  wire task_type       pop_task,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output logic [CHAR_W-1:0]   rsp_char_code,
   output logic                rsp_last_char
);

   localparam int BCD_W = 4 * MAX_DIGITS;
   localparam int IDX_W = $clog2(MAX_DIGITS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CONV  = 3'd1;
   localparam logic [2:0] S_COUNT = 3'd2;
   localparam logic [2:0] S_SIGN  = 3'd3;
   localparam logic [2:0] S_RAW   = 3'd4;
   localparam logic [2:0] S_DIGIT = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic               ovf_ff, ovf_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   logic [BCD_W-1:0]   bcd_next;
   logic [BCD_W:0]     dabbled;
   logic               carry_out;
   logic [IDX_W-1:0]   top_idx;
   logic [3:0]         digit;
   logic               out_load;

   // top bit of the result is the carry out of the highest digit
   function automatic logic [BCD_W:0] dabble(input logic [BCD_W-1:0] b,
                                             input logic bit_in);
      logic [BCD_W-1:0] adj;
      adj = b;
      for (int d = 0; d < MAX_DIGITS; d++) begin
         if (adj[4*d +: 4] >= 4'd5) begin
            adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
         end
      end
      return {adj, bit_in};
   endfunction

   always_comb begin
      bcd_next  = bcd_ff;
      carry_out = 1'b0;
      dabbled   = '0;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         dabbled   = dabble(bcd_next, mag_ff[VALUE_W-1-b]);
         bcd_next  = dabbled[BCD_W-1:0];
         carry_out = carry_out | dabbled[BCD_W];
      end
   end

   always_comb begin
      top_idx = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) begin
            top_idx = IDX_W'(i);
         end
      end
   end

   assign digit    = 4'(bcd_ff >> {idx_ff, 2'b00});
   assign out_load = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      mode_in      = mode_ff;
      step_in      = step_ff;
      bcd_in       = bcd_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      pop          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_stat.can_pop) begin
               pop     = 1'b1;
               mag_in  = pop_task.mag;
               neg_in  = pop_task.neg;
               mode_in = pop_task.mode;
               bcd_in  = '0;
               ovf_in  = 1'b0;
               step_in = STEP_W'(1) << pop_task.mode;
               if (pop_task.mode == MODE_RAW) begin
                  state_in = pop_task.neg ? S_SIGN : S_RAW;
               end else begin
                  state_in = S_CONV;
               end
            end
         end
         S_CONV: begin
            bcd_in  = bcd_next;
            ovf_in  = ovf_ff | carry_out;
            mag_in  = mag_ff << BITS_PER_STEP;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = S_COUNT;
            end
         end
         S_COUNT: begin
            // more digits than kept: emit all kept digits, zeros included
            idx_in   = ovf_ff ? IDX_W'(MAX_DIGITS - 1) : top_idx;
            state_in = neg_ff ? S_SIGN : S_DIGIT;
         end
         S_SIGN: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               char_in      = ASCII_MINUS;
               last_in      = 1'b0;
               state_in     = (mode_ff == MODE_RAW) ? S_RAW : S_DIGIT;
            end
         end
         S_RAW: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               char_in      = mag_ff[VALUE_W-1 -: CHAR_W];
               last_in      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DIGIT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               char_in      = ASCII_ZERO + {4'd0, digit};
               last_in      = (idx_ff == '0);
               idx_in       = idx_ff - IDX_W'(1);
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      mode_ff <= mode_in;
      step_ff <= step_in;
      bcd_ff  <= bcd_in;
      ovf_ff  <= ovf_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

endmodule
`default_nettype wire

[hw/rtl/integer_to_decimal_ascii.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii
// Converts a 16/32/64-bit integer, signed or unsigned, to ASCII decimal, most
// significant first; a raw byte passes as is, or as a minus and its negation
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_value, req_mode, req_is_signed
//   rsp      out        rsp_valid, rsp_ready, rsp_char_code, rsp_last_char
//
// a request waits in a two-entry queue; the back end loads it, converts it
// to BCD (8 bits a cycle) for 16/32/64 bits, counts the digits, then emits
// the characters while the output is not stalled
// synchronous reset clears the queue, the sequencer and the output valid flag
// a stalled output holds the back end; until its two entries are full the queue keeps taking requests
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii import itda_pkg::*; #(
   parameter int MAX_DIGITS = 20
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic [MODE_W-1:0]  req_mode,
   input  wire logic               req_is_signed,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [CHAR_W-1:0]       rsp_char_code,
   output logic                    rsp_last_char
);

   queue_stat_type q_stat;
   task_type       push_task;
   task_type       pop_task;
   logic           push;
   logic           pop;

   itda_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_mode      (req_mode),
      .req_is_signed (req_is_signed),
      .q_stat        (q_stat),
      .push          (push),
      .push_task     (push_task)
   );

   itda_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_task (push_task),
      .pop       (pop),
      .pop_task  (pop_task),
      .q_stat    (q_stat)
   );

   itda_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_stat        (q_stat),
      .pop_task      (pop_task),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_stat.can_pop)
      else $error("pop from empty queue");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> q_stat.can_pop)
      else $error("accepted request not queued");

   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("output valid right after reset");

endmodule
`default_nettype wire

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the integer to decimal ASCII converter. A table of directed
// requests (zero, extremes of every width, most negative values, ignored upper
// bits, raw bytes with and without sign) is followed by random requests. Each
// accepted request gets its expected character run from its table text or a
// predictor of the conversion, and is compared character by character with the
// output stream. Both channels stall at random, with a stretch of no stalls.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import itda_pkg::*;

   localparam int DIGIT_LIMIT  = 20;
   localparam int TEXT_W       = 8 * 20;
   localparam int RANDOM_ITEMS = 450;
   localparam int REPORT_MAX   = 10;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } ascii_char_type;

   // text of zero means the run comes from the predictor
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [MODE_W-1:0]  mode;
      logic               sgn;
      logic [TEXT_W-1:0]  text;
   } stim_row_type;

   stim_row_type directed_rows [24] = '{
      '{64'd0,                    MODE_64,  1'b0, "0"},
      '{64'hFFFF_FFFF_FFFF_FFFF,  MODE_64,  1'b0, "18446744073709551615"},
      '{64'h8000_0000_0000_0000,  MODE_64,  1'b1, "-9223372036854775808"},
      '{64'hFFFF_FFFF_FFFF_FFFF,  MODE_64,  1'b1, "-1"},
      '{64'h7FFF_FFFF_FFFF_FFFF,  MODE_64,  1'b1, "9223372036854775807"},
      '{64'd10000000000000000000, MODE_64,  1'b0, "10000000000000000000"},
      '{64'd9999999999999999999,  MODE_64,  1'b0, '0},
      '{64'hFFFF_FFFF_0000_8000,  MODE_16,  1'b1, "-32768"},
      '{64'h0000_0000_0000_FFFF,  MODE_16,  1'b0, "65535"},
      '{64'h0000_0000_0000_7FFF,  MODE_16,  1'b1, "32767"},
      '{64'h0000_0000_0000_0000,  MODE_16,  1'b1, "0"},
      '{64'h1234_5678_0001_0000,  MODE_16,  1'b0, "0"},
      '{64'h0000_0000_8000_0000,  MODE_32,  1'b1, "-2147483648"},
      '{64'h0000_0000_FFFF_FFFF,  MODE_32,  1'b0, "4294967295"},
      '{64'hABCD_0000_0000_0000,  MODE_32,  1'b1, "0"},
      '{64'd9,                    MODE_32,  1'b0, "9"},
      '{64'd10,                   MODE_32,  1'b1, "10"},
      '{64'h41,                   MODE_RAW, 1'b0, "A"},
      '{64'hC1,                   MODE_RAW, 1'b1, "-?"},
      '{64'hD0,                   MODE_RAW, 1'b1, "-0"},
      '{64'h80,                   MODE_RAW, 1'b1, '0},
      '{64'hFF,                   MODE_RAW, 1'b0, '0},
      '{64'hFFFF_FFFF_FFFF_FF00,  MODE_RAW, 1'b1, '0},
      '{64'h7F,                   MODE_RAW, 1'b1, '0}
   };

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [VALUE_W-1:0] req_value     = '0;
   logic [MODE_W-1:0]  req_mode      = MODE_RAW;
   logic               req_is_signed = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [CHAR_W-1:0]  rsp_char_code;
   logic               rsp_last_char;

   logic [TEXT_W-1:0]  req_text      = '0;
   logic               steady        = 1'b0;
   ascii_char_type     pending_chars [$];
   int                 ready_hold;
   int                 n_requests;
   int                 n_chars;
   int                 n_errors;
   int                 n_mode [4];

   integer_to_decimal_ascii #(
      .MAX_DIGITS(DIGIT_LIMIT)
   ) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_value    (req_value),
      .req_mode     (req_mode),
      .req_is_signed(req_is_signed),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_char_code(rsp_char_code),
      .rsp_last_char(rsp_last_char)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [VALUE_W-1:0] width_mask(input logic [MODE_W-1:0] mode);
      int width;
      width = 8 << mode;
      return (width == VALUE_W) ? '1 : ((64'd1 << width) - 64'd1);
   endfunction

   function automatic void push_run(ref ascii_char_type run [$]);
      ascii_char_type tail;
      tail = run.pop_back();
      tail.last = 1'b1;
      run.push_back(tail);
      foreach (run[i]) pending_chars.push_back(run[i]);
   endfunction

   function automatic void predict_chars(input logic [VALUE_W-1:0] value,
                                         input logic [MODE_W-1:0]  mode,
                                         input logic               sgn);
      logic [VALUE_W-1:0] mask;
      logic [VALUE_W-1:0] bits;
      logic [VALUE_W-1:0] mag;
      logic               neg;
      int                 width;
      int                 nd;
      logic [CHAR_W-1:0]  digits [DIGIT_LIMIT];
      ascii_char_type     run [$];
      width = 8 << mode;
      mask  = width_mask(mode);
      bits  = value & mask;
      neg   = sgn && bits[width-1];
      mag   = neg ? ((~bits + 64'd1) & mask) : bits;
      if (neg) run.push_back('{ASCII_MINUS, 1'b0});
      if (mode == MODE_RAW) begin
         run.push_back('{mag[CHAR_W-1:0], 1'b0});
      end else begin
         nd = 0;
         do begin
            digits[nd] = ASCII_ZERO + CHAR_W'(mag % 64'd10);
            nd++;
            mag = mag / 64'd10;
         end while (mag != 0 && nd < DIGIT_LIMIT);
         while (nd > 0) begin
            nd--;
            run.push_back('{digits[nd], 1'b0});
         end
      end
      push_run(run);
   endfunction

   function automatic void expect_text(input logic [TEXT_W-1:0] text);
      ascii_char_type run [$];
      for (int i = TEXT_W / 8 - 1; i >= 0; i--) begin
         if (text[8*i +: 8] != 8'h00) run.push_back('{text[8*i +: 8], 1'b0});
      end
      push_run(run);
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [VALUE_W-1:0] random_value(input logic [MODE_W-1:0] mode);
      logic [VALUE_W-1:0] mask;
      logic [VALUE_W-1:0] raw;
      logic [VALUE_W-1:0] low;
      logic [VALUE_W-1:0] top;
      int                 r;
      int                 k;
      mask = width_mask(mode);
      raw  = {$urandom, $urandom};
      top  = (mask >> 1) + 64'd1;
      r    = $urandom_range(0, 99);
      if (r < 40) begin
         low = raw;
      end else if (r < 55) begin
         low = 64'($urandom_range(0, 20));
      end else if (r < 70) begin
         k = $urandom_range(0, (mode == MODE_64) ? 19 : (mode == MODE_32) ? 9 : 4);
         low = 64'd1;
         repeat (k) low = low * 64'd10;
         low = low + 64'($urandom_range(0, 2)) - 64'd1;
      end else if (r < 85) begin
         low = top + 64'($urandom_range(0, 2)) - 64'd1;
      end else begin
         low = mask - 64'($urandom_range(0, 20));
      end
      return (raw & ~mask) | (low & mask);
   endfunction

   task automatic send_request(input logic [VALUE_W-1:0] value,
                               input logic [MODE_W-1:0]  mode,
                               input logic               sgn,
                               input logic [TEXT_W-1:0]  text);
      int gap;
      gap = steady ? 0 : idle_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_value     <= value;
      req_mode      <= mode;
      req_is_signed <= sgn;
      req_text      <= text;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   // request and result monitor
   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset && req_valid && req_ready) begin
         n_requests++;
         n_mode[req_mode]++;
         if (req_text != '0) expect_text(req_text);
         else predict_chars(req_value, req_mode, req_is_signed);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         n_chars++;
         if (pending_chars.size() == 0) begin
            n_errors++;
            if (n_errors <= REPORT_MAX)
               $display("%0t: unexpected char 0x%02h last %0b", $realtime, rsp_char_code,
                        rsp_last_char);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_char_code !== want.code || rsp_last_char !== want.last) begin
               n_errors++;
               if (n_errors <= REPORT_MAX)
                  $display("%0t: char 0x%02h last %0b, expected 0x%02h last %0b", $realtime,
                           rsp_char_code, rsp_last_char, want.code, want.last);
            end
         end
      end
   end

   // output back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (steady) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else if (rsp_ready) begin
         rsp_ready <= 1'b0;
         ready_hold = idle_len();
      end else begin
         rsp_ready <= 1'b1;
         ready_hold = $urandom_range(0, 12);
      end
   end

   initial begin
      logic [MODE_W-1:0] mode;
      logic              sgn;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i])
         send_request(directed_rows[i].value, directed_rows[i].mode, directed_rows[i].sgn,
                      directed_rows[i].text);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150 || n == 320) wait_for_drain();
         steady = (n >= 200 && n < 250);
         mode   = MODE_W'($urandom_range(0, 3));
         sgn    = 1'($urandom_range(0, 1));
         send_request(random_value(mode), mode, sgn, '0);
      end
      steady = 1'b0;
      @(negedge clock);
      req_valid <= 1'b0;
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("checked %0d characters of %0d requests (raw %0d, 16-bit %0d, 32-bit %0d, %s%0d)",
               n_chars, n_requests, n_mode[0], n_mode[1], n_mode[2], "64-bit ", n_mode[3]);
      $display("signed and unsigned, extreme and most negative values, %0d mismatches",
               n_errors);
      if (n_errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d characters still expected", pending_chars.size());
      $display("tb: failure");
      $finish;
   end

endmodule
